FILE: src/meo_pkg.sv
package meo_pkg;

    // Widths of the fields on the stream ports.
    localparam int unsigned FIELD_W    = 16;
    localparam int unsigned ODOM_W     = 48;
    localparam int unsigned IN_DATA_W  = 7 * FIELD_W;
    localparam int unsigned OUT_DATA_W = 3 * FIELD_W + 3 * ODOM_W;

    // Speed per count of delta, Q32: round(2^32 * 23.56194490192345 / 1560).
    localparam int unsigned           SPEED_K_W = 26;
    localparam logic [SPEED_K_W-1:0]  SPEED_K   = 26'd64870374;

    // Wheel counts per unit of commanded pose, Q32: round(2^32 * 4.16 / pi).
    localparam int unsigned           POSE_K_W  = 33;
    localparam logic [POSE_K_W-1:0]   POSE_K    = 33'd5687263093;

    // Pose combinations 5x +- 5y + w fit in 20 signed bits.
    localparam int unsigned POSE_SUM_W = 20;
    localparam int unsigned POSE_MAG_W = 19;
    localparam int unsigned POSE_PRD_W = POSE_MAG_W + POSE_K_W;

    // Velocity magnitudes at or above this always saturate, so the datapath
    // clamps them here and keeps the multiply narrow.
    localparam logic [FIELD_W-1:0] VEL_MAG_CAP = 16'h8000;
    localparam int unsigned        VEL_MUL_W   = 11;
    localparam logic [VEL_MUL_W-1:0] VEL_MUL_LIN = 11'd250;
    localparam logic [VEL_MUL_W-1:0] VEL_MUL_ROT = 11'd1250;
    localparam int unsigned        VEL_A_W     = 26;
    localparam int unsigned        VEL_P_W     = VEL_A_W + SPEED_K_W;
    localparam int unsigned        VEL_Y_W     = VEL_P_W - 32;
    localparam logic [VEL_Y_W-1:0] VEL_Y_NEG_LIM = 20'h08000;
    localparam logic [VEL_Y_W-1:0] VEL_Y_POS_LIM = 20'h07FFF;
    localparam logic [FIELD_W-1:0] VEL_NEG_MAX   = 16'h8000;
    localparam logic [FIELD_W-1:0] VEL_POS_MAX   = 16'h7FFF;

    // Odometer position is scaled by 1 / (100 * 2^18) after the speed factor.
    localparam int unsigned ODOM_SHIFT = 18;
    localparam int unsigned ODOM_DIV   = 100;

    // Body axes in result order.
    localparam int unsigned AXIS_X = 0;
    localparam int unsigned AXIS_Y = 1;
    localparam int unsigned AXIS_W = 2;

    typedef logic signed [FIELD_W-1:0] t_field;
    typedef logic signed [ODOM_W-1:0]  t_odom;

endpackage

FILE: src/mecanum_encoder_odometry.sv
// Channel    Direction  Beat contents
// s_axis     in         tdata: count_a..count_d, pose_x/y/w_milli; tuser: mode
// m_axis     out        tdata: vel_x/y/w_milli, odom_x/y/w_q16
//
// One beat in and one beat out per cycle while the output is not stalled;
// each beat passes stages 0 to 10 in turn. The rate is set by the wheel
// state registers, which are read and updated once per beat in a single stage.
// Reset clears the stage valid bits, the wheel references and the totals.
// Every stage advances on its own when empty or when the next one moves, so
// a stalled output only holds the stages that carry data.
module mecanum_encoder_odometry #(
    parameter int unsigned COUNTER_WIDTH = 16,
    parameter int unsigned TOTAL_WIDTH   = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // count_a, count_b, count_c, count_d, pose_x_milli, pose_y_milli, pose_w_milli
    input  logic [meo_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    // mode
    input  logic                            i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // vel_x_milli, vel_y_milli, vel_w_milli, odom_x_q16, odom_y_q16, odom_w_q16
    output logic [meo_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata
);

    import meo_pkg::*;

    localparam int unsigned NSTG  = 11;
    localparam int unsigned CW    = COUNTER_WIDTH;
    localparam int unsigned TW    = TOTAL_WIDTH;
    localparam int unsigned DW    = CW + 1;
    localparam int unsigned RAW_W = CW + 2;
    localparam int unsigned VSW   = CW + 3;
    localparam int unsigned VMW   = CW + 2;
    localparam int unsigned MAGW  = (VMW > FIELD_W) ? VMW : FIELD_W;
    localparam int unsigned TSW   = TW + 2;
    localparam int unsigned AW    = TW + 4;
    localparam int unsigned PW    = AW + SPEED_K_W;
    localparam int unsigned XW    = PW - ODOM_SHIFT;
    localparam int unsigned RW    = XW - 6;
    localparam int unsigned XL    = XW / 2;
    localparam int unsigned XH    = XW - XL;
    localparam int unsigned RL    = RW / 2;
    localparam int unsigned RH    = RW - RL;
    localparam int unsigned MW    = XW + RW;
    localparam int unsigned QW    = RW;

    // Reciprocal of the divisor, exact to within one step for any x < 2^XW.
    localparam logic [63:0] RECIP = (64'd1 << XW) / 64'(ODOM_DIV);

    localparam logic signed [RAW_W-1:0] C_HALF = {3'b001, {(CW-1){1'b0}}};
    localparam logic signed [RAW_W-1:0] C_FULL = {2'b01, {CW{1'b0}}};

    // Stage valid bits and per-stage load enables.
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] stg_en;

    // Stage 0: captured beat.
    logic                  r_mode;
    logic [CW-1:0]         r_cnt    [4];
    logic [POSE_MAG_W-1:0] r_pmag   [4];
    logic                  r_pneg   [4];

    // Wheel state.
    logic [CW-1:0]         r_last   [4];
    logic [TW-1:0]         r_tot    [4];

    // Stage 1 to 4.
    logic signed [DW-1:0]  r_d      [4];
    logic signed [VSW-1:0] r_vs     [3];
    logic signed [TSW-1:0] r_ts     [3];
    logic [VEL_A_W-1:0]    r_va     [3];
    logic [AW-1:0]         r_oa     [3];
    logic [VEL_P_W-1:0]    r_vp     [3];
    logic [VEL_P_W-1:0]    r_pl     [3];
    logic [AW-1:0]         r_ph     [3];

    // Stage 6 to 9: reciprocal multiply and correction.
    logic [XH+RH-1:0]      r_hh     [3];
    logic [XH+RL-1:0]      r_hl     [3];
    logic [XL+RH-1:0]      r_lh     [3];
    logic [XL+RL-1:0]      r_ll     [3];
    logic [MW-1:0]         r_m1     [3];
    logic [MW-1:0]         r_m2     [3];
    logic [XW-1:0]         r_qm     [3];

    // Values carried along the pipe.
    logic                  r_vneg_p [3:4][3];
    logic                  r_oneg_p [3:9][3];
    t_field                r_vel_p  [5:10][3];
    logic [XW-1:0]         r_x_p    [5:9][3];
    logic [QW-1:0]         r_qe_p   [8:9][3];
    t_odom                 r_odom   [3];

    // Next values.
    logic [POSE_MAG_W-1:0] n_pmag   [4];
    logic                  n_pneg   [4];
    logic signed [DW-1:0]  n_d      [4];
    logic [TW-1:0]         n_tot    [4];
    logic signed [VSW-1:0] n_vs     [3];
    logic signed [TSW-1:0] n_ts     [3];
    logic                  n_vneg   [3];
    logic [VEL_A_W-1:0]    n_va     [3];
    logic                  n_oneg   [3];
    logic [AW-1:0]         n_oa     [3];
    t_field                n_vel    [3];
    logic [XW-1:0]         n_x      [3];
    logic [QW-1:0]         n_qe     [3];
    logic [XW-1:0]         n_qm     [3];
    t_odom                 n_odom   [3];

    // Handshake: a stage loads when empty or when its successor loads.
    always_comb begin
        stg_en[NSTG-1] = ~r_vld[NSTG-1] | i_m_axis_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            stg_en[k] = ~r_vld[k] | stg_en[k+1];
        end
    end

    assign o_s_axis_tready = stg_en[0];
    assign o_m_axis_tvalid = r_vld[NSTG-1];
    assign o_m_axis_tdata  = {r_odom[AXIS_W], r_odom[AXIS_Y], r_odom[AXIS_X],
                              r_vel_p[10][AXIS_W], r_vel_p[10][AXIS_Y],
                              r_vel_p[10][AXIS_X]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stg_en[0]) begin
                r_vld[0] <= i_s_axis_tvalid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (stg_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Pose combinations for the wheel totals, split into sign and magnitude.
    always_comb begin
        logic signed [POSE_SUM_W-1:0] px, py, pw, px5, py5;
        logic signed [POSE_SUM_W-1:0] c [4];
        logic signed [POSE_SUM_W-1:0] cabs;
        px  = POSE_SUM_W'(signed'(i_s_axis_tdata[4*FIELD_W +: FIELD_W]));
        py  = POSE_SUM_W'(signed'(i_s_axis_tdata[5*FIELD_W +: FIELD_W]));
        pw  = POSE_SUM_W'(signed'(i_s_axis_tdata[6*FIELD_W +: FIELD_W]));
        px5 = (px <<< 2) + px;
        py5 = (py <<< 2) + py;
        c[0] =  px5 + py5 + pw;
        c[1] = -px5 + py5 + pw;
        c[2] = -px5 - py5 + pw;
        c[3] =  px5 - py5 + pw;
        for (int i = 0; i < 4; i++) begin
            cabs      = c[i][POSE_SUM_W-1] ? -c[i] : c[i];
            n_pneg[i] = c[i][POSE_SUM_W-1];
            n_pmag[i] = cabs[POSE_MAG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[0]) begin
            r_mode <= i_s_axis_tuser;
            for (int i = 0; i < 4; i++) begin
                r_cnt[i]  <= CW'(i_s_axis_tdata[i*FIELD_W +: FIELD_W]);
                r_pmag[i] <= n_pmag[i];
                r_pneg[i] <= n_pneg[i];
            end
        end
    end

    // Stage 1: wrapped wheel deltas, running totals, or totals from the pose.
    always_comb begin
        logic signed [RAW_W-1:0]    raw, adj;
        logic [POSE_PRD_W-1:0]      prd;
        logic signed [VEL_Y_W:0]    ptot;
        for (int i = 0; i < 4; i++) begin
            raw = signed'({2'b00, r_last[i]}) - signed'({2'b00, r_cnt[i]});
            if (raw < -C_HALF) begin
                adj = raw + C_FULL;
            end else if (raw > C_HALF) begin
                adj = raw - C_FULL;
            end else begin
                adj = raw;
            end
            prd  = POSE_PRD_W'(r_pmag[i]) * POSE_PRD_W'(POSE_K);
            ptot = signed'({1'b0, prd[POSE_PRD_W-1:32]});
            if (r_pneg[i]) begin
                ptot = -ptot;
            end
            if (r_mode) begin
                n_d[i]   = '0;
                n_tot[i] = TW'(ptot);
            end else begin
                n_d[i]   = adj[DW-1:0];
                n_tot[i] = r_tot[i] + TW'(adj);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_last[i] <= '0;
                r_tot[i]  <= '0;
            end
        end else if (stg_en[1] && r_vld[0]) begin
            for (int i = 0; i < 4; i++) begin
                r_last[i] <= r_cnt[i];
                r_tot[i]  <= n_tot[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[1]) begin
            for (int i = 0; i < 4; i++) begin
                r_d[i] <= n_d[i];
            end
        end
    end

    // Stage 2: inverse kinematics sums on deltas and on totals.
    always_comb begin
        logic signed [VSW-1:0] d [4];
        logic signed [TSW-1:0] t [4];
        for (int i = 0; i < 4; i++) begin
            d[i] = VSW'(r_d[i]);
            t[i] = TSW'(signed'(r_tot[i]));
        end
        n_vs[AXIS_X] = d[0] - d[1] - d[2] + d[3];
        n_vs[AXIS_Y] = d[0] + d[1] - d[2] - d[3];
        n_vs[AXIS_W] = d[0] + d[1] + d[2] + d[3];
        n_ts[AXIS_X] = t[0] - t[1] - t[2] + t[3];
        n_ts[AXIS_Y] = t[0] + t[1] - t[2] - t[3];
        n_ts[AXIS_W] = t[0] + t[1] + t[2] + t[3];
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[2]) begin
            r_vs <= n_vs;
            r_ts <= n_ts;
        end
    end

    // Stage 3: magnitudes, velocity clamp and the per-axis scale factors.
    always_comb begin
        logic signed [VSW-1:0] vabs;
        logic [MAGW-1:0]       vmag;
        logic [FIELD_W-1:0]    vclp;
        logic signed [TSW-1:0] tabs;
        logic [AW-1:0]         omag;
        for (int j = 0; j < 3; j++) begin
            n_vneg[j] = r_vs[j][VSW-1];
            vabs      = n_vneg[j] ? -r_vs[j] : r_vs[j];
            vmag      = MAGW'(vabs[VMW-1:0]);
            if (vmag >= MAGW'(VEL_MAG_CAP)) begin
                vclp = VEL_MAG_CAP;
            end else begin
                vclp = vmag[FIELD_W-1:0];
            end
            if (j == AXIS_W) begin
                n_va[j] = VEL_A_W'(vclp) * VEL_A_W'(VEL_MUL_ROT);
            end else begin
                n_va[j] = VEL_A_W'(vclp) * VEL_A_W'(VEL_MUL_LIN);
            end
            n_oneg[j] = r_ts[j][TSW-1];
            tabs      = n_oneg[j] ? -r_ts[j] : r_ts[j];
            omag      = AW'(unsigned'(tabs));
            if (j == AXIS_W) begin
                n_oa[j] = (omag << 2) + omag;
            end else begin
                n_oa[j] = omag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[3]) begin
            r_va          <= n_va;
            r_oa          <= n_oa;
            r_vneg_p[3]   <= n_vneg;
            r_oneg_p[3]   <= n_oneg;
        end
    end

    // Stage 4: speed factor products, the odometer word cut in two pieces.
    always_ff @(posedge i_clk) begin
        if (stg_en[4]) begin
            for (int j = 0; j < 3; j++) begin
                r_vp[j] <= VEL_P_W'(r_va[j]) * VEL_P_W'(SPEED_K);
                r_pl[j] <= VEL_P_W'(r_oa[j][SPEED_K_W-1:0]) * VEL_P_W'(SPEED_K);
                r_ph[j] <= AW'(r_oa[j][AW-1:SPEED_K_W]) * AW'(SPEED_K);
            end
            r_vneg_p[4] <= r_vneg_p[3];
            r_oneg_p[4] <= r_oneg_p[3];
        end
    end

    // Stage 5: saturated velocity; odometer product reassembled and shifted.
    always_comb begin
        logic [VEL_Y_W-1:0] y;
        logic [PW-1:0]      p;
        for (int j = 0; j < 3; j++) begin
            y = r_vp[j][VEL_P_W-1:32];
            if (r_vneg_p[4][j]) begin
                n_vel[j] = (y >= VEL_Y_NEG_LIM) ? VEL_NEG_MAX : -y[FIELD_W-1:0];
            end else begin
                n_vel[j] = (y >= VEL_Y_POS_LIM) ? VEL_POS_MAX : y[FIELD_W-1:0];
            end
            p       = (PW'(r_ph[j]) << SPEED_K_W) + PW'(r_pl[j]);
            n_x[j]  = p[PW-1:ODOM_SHIFT];
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[5]) begin
            r_vel_p[5]  <= n_vel;
            r_x_p[5]    <= n_x;
            r_oneg_p[5] <= r_oneg_p[4];
        end
    end

    // Stage 6: four partial products of x times the reciprocal.
    always_ff @(posedge i_clk) begin
        if (stg_en[6]) begin
            for (int j = 0; j < 3; j++) begin
                r_hh[j] <= (XH+RH)'(r_x_p[5][j][XW-1:XL]) * (XH+RH)'(RECIP[RW-1:RL]);
                r_hl[j] <= (XH+RL)'(r_x_p[5][j][XW-1:XL]) * (XH+RL)'(RECIP[RL-1:0]);
                r_lh[j] <= (XL+RH)'(r_x_p[5][j][XL-1:0]) * (XL+RH)'(RECIP[RW-1:RL]);
                r_ll[j] <= (XL+RL)'(r_x_p[5][j][XL-1:0]) * (XL+RL)'(RECIP[RL-1:0]);
            end
            r_vel_p[6]  <= r_vel_p[5];
            r_x_p[6]    <= r_x_p[5];
            r_oneg_p[6] <= r_oneg_p[5];
        end
    end

    // Stage 7: partial products paired up.
    always_ff @(posedge i_clk) begin
        if (stg_en[7]) begin
            for (int j = 0; j < 3; j++) begin
                r_m1[j] <= (MW'(r_hh[j]) << (XL + RL)) + MW'(r_ll[j]);
                r_m2[j] <= (MW'(r_hl[j]) << XL) + (MW'(r_lh[j]) << RL);
            end
            r_vel_p[7]  <= r_vel_p[6];
            r_x_p[7]    <= r_x_p[6];
            r_oneg_p[7] <= r_oneg_p[6];
        end
    end

    // Stage 8: quotient estimate, at most one below the true quotient.
    always_comb begin
        logic [MW-1:0] s;
        for (int j = 0; j < 3; j++) begin
            s       = r_m1[j] + r_m2[j];
            n_qe[j] = s[MW-1:XW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[8]) begin
            r_qe_p[8]   <= n_qe;
            r_vel_p[8]  <= r_vel_p[7];
            r_x_p[8]    <= r_x_p[7];
            r_oneg_p[8] <= r_oneg_p[7];
        end
    end

    // Stage 9: estimate times the divisor, by shifts and adds.
    always_comb begin
        logic [XW-1:0] q;
        for (int j = 0; j < 3; j++) begin
            q       = XW'(r_qe_p[8][j]);
            n_qm[j] = (q << 6) + (q << 5) + (q << 2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[9]) begin
            r_qm        <= n_qm;
            r_qe_p[9]   <= r_qe_p[8];
            r_vel_p[9]  <= r_vel_p[8];
            r_x_p[9]    <= r_x_p[8];
            r_oneg_p[9] <= r_oneg_p[8];
        end
    end

    // Stage 10: quotient correction, sign and 48-bit result.
    always_comb begin
        logic [XW-1:0]        rem;
        logic [QW-1:0]        q;
        logic signed [QW:0]   sq;
        for (int j = 0; j < 3; j++) begin
            rem = r_x_p[9][j] - r_qm[j];
            q   = r_qe_p[9][j] + QW'(rem >= XW'(ODOM_DIV));
            sq  = signed'({1'b0, q});
            if (r_oneg_p[9][j]) begin
                sq = -sq;
            end
            n_odom[j] = ODOM_W'(sq);
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[10]) begin
            r_odom      <= n_odom;
            r_vel_p[10] <= r_vel_p[9];
        end
    end

endmodule
